// File: rtl/core/slt_pkg.sv
// shared types, constants and tables for the signal level tone squelch block
// no dependencies; imported by every module of the block
`default_nettype none

package slt_pkg;

  // operation codes on the input channel
  localparam logic [1:0] OP_SIGNAL = 2'd0;
  localparam logic [1:0] OP_KNOB   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HANG_RELOAD    = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_RELOAD = 2'd1;
  localparam logic [1:0] CFG_WINDOW_WIDTH   = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration reset values
  localparam logic [15:0] HANG_RELOAD_RST    = 16'd100;
  localparam logic [15:0] TIMEOUT_RELOAD_RST = 16'd30000;
  localparam logic [3:0]  WINDOW_WIDTH_RST   = 4'd2;

  // parameter defaults
  localparam int CLOCK_HZ_DEF   = 8000000;
  localparam int TONE_COUNT_DEF = 11;

  // averaging group
  localparam int AVG_COUNT = 4;
  localparam int AVG_CNT_W = $clog2(AVG_COUNT);
  localparam int AVG_SUM_W = 8 + AVG_CNT_W;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;

  localparam int TABLE_SLOTS = 16;

  // level thresholds; slot 1 is replaced by the squelch level
  localparam logic [7:0] LEVEL_TABLE [TABLE_SLOTS] = '{
    8'd0, 8'd255, 8'd30, 8'd36, 8'd44, 8'd49, 8'd53, 8'd65, 8'd75, 8'd98, 8'd115,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  // tone frequency in Hz per slot
  localparam int TONE_FREQ [TABLE_SLOTS] = '{
    6600, 6400, 6300, 6200, 6100, 6000, 5900, 5800, 5700, 5600, 5500,
    5500, 5500, 5500, 5500, 5500
  };

  // classified work for the back end
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LEVEL,
    CMD_KNOB,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/signal_level_tone_squelch_ptt_top.sv
// top level of the signal level tone squelch block
// instantiates slt_front, slt_queue and slt_back; uses slt_pkg
`default_nettype none

// Signal-strength samples (operation 0) are summed in groups of four; every
// fourth one moves a hysteresis window whose centre is matched against the
// level table (slot 1 is the squelch level) to pick a tone of 6600 down to
// 5500 Hz and its timer period, and runs the transmit key hang and timeout
// counters. Squelch knob samples (operation 1) set the squelch level to the
// sample plus window_width, saturating at 255. Period ticks (operation 2)
// slide the current period one step toward the target and refresh the
// half-period compare value. Operation 3 changes nothing. Every input
// transaction yields exactly one result transaction that shows the whole
// state after that step. The front end classifies a transaction in the cycle
// it is accepted and writes a command to a two-entry queue; the back end
// executes one command per cycle while the result side takes them, straight
// into the state registers, which drive the result ports. Throughput is one
// transaction per clock with out_ready held high; out_valid is registered
// behind the queue. When the result is stalled the queue absorbs two more
// transactions before in_ready drops. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata, by the user only while the block
// is idle, which the block does not enforce; a write to an index outside
// the register list is ignored. Reset is synchronous, active low.

module signal_level_tone_squelch_ptt_top
  import slt_pkg::*;
#(
  parameter int CLOCK_HZ   = CLOCK_HZ_DEF,
  parameter int TONE_COUNT = TONE_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input transactions
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_operation,
  input  wire logic [7:0]             in_sample,
  // result transactions
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_transmit_key,
  output logic [3:0]                  out_tone_index,
  output logic [15:0]                 out_period_target,
  output logic [15:0]                 out_period_now,
  output logic [15:0]                 out_compare_now
);

  // front to queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  // queue to back
  logic q_pop;
  logic q_pop_ready;
  logic q_not_empty;
  cmd_t q_head_cmd;

  // accept and classify, owns the sample averaging
  slt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_sample    (in_sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_push_cmd)
  );

  // decouples acceptance from result backpressure
  slt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head_cmd)
  );

  // executes commands, one per cycle while the result side takes them
  slt_back #(
    .CLOCK_HZ   (CLOCK_HZ),
    .TONE_COUNT (TONE_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .q_valid           (q_not_empty),
    .q_cmd             (q_head_cmd),
    .q_ready           (q_pop_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_transmit_key  (out_transmit_key),
    .out_tone_index    (out_tone_index),
    .out_period_target (out_period_target),
    .out_period_now    (out_period_now),
    .out_compare_now   (out_compare_now)
  );

  // pop only when something is queued and the back end can take it
  assign q_pop = q_not_empty && q_pop_ready;

endmodule

`default_nettype wire

// File: rtl/core/slt_front.sv
// front end: accepts input transactions, sums signal samples in groups
// and classifies each transaction into a command; uses slt_pkg
`default_nettype none

module slt_front
  import slt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_sample,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [AVG_SUM_W-1:0] sum_r, sum_nxt;
  logic [AVG_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AVG_SUM_W-1:0] sum_add;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign sum_add  = sum_r + AVG_SUM_W'(in_sample);

  always_comb begin
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    q_cmd.kind = CMD_NONE;
    q_cmd.data = in_sample;
    unique case (in_operation)
      OP_SIGNAL: begin
        if (cnt_r == AVG_CNT_W'(AVG_COUNT - 1)) begin
          sum_nxt    = '0;
          cnt_nxt    = '0;
          q_cmd.kind = CMD_LEVEL;
          q_cmd.data = sum_add[AVG_SUM_W-1 -: 8];
        end else begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_r + AVG_CNT_W'(1);
        end
      end
      OP_KNOB: q_cmd.kind = CMD_KNOB;
      OP_TICK: q_cmd.kind = CMD_TICK;
      default: q_cmd.kind = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (q_push) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slt_queue.sv
// short command queue between front and back end
// uses slt_pkg for the command type and depth
`default_nettype none

module slt_queue
  import slt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/slt_back.sv
// back end: hysteresis window, tone match, squelch key logic and period slide
// holds the configuration registers; uses slt_pkg
`default_nettype none

module slt_back
  import slt_pkg::*;
#(
  parameter int CLOCK_HZ   = CLOCK_HZ_DEF,
  parameter int TONE_COUNT = TONE_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   q_valid,
  input  cmd_t                        q_cmd,
  output logic                        q_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_transmit_key,
  output logic [3:0]                  out_tone_index,
  output logic [15:0]                 out_period_target,
  output logic [15:0]                 out_period_now,
  output logic [15:0]                 out_compare_now
);

  // timer period per slot, round(CLOCK_HZ / f) - 1, fixed at elaboration
  logic [15:0] period_rom [TABLE_SLOTS];

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_period
    localparam int Freq   = TONE_FREQ[g];
    localparam int Period = (((2 * CLOCK_HZ) / Freq) + 1) / 2 - 1;
    assign period_rom[g] = 16'(Period);
  end

  logic [15:0] hang_reload_r, timeout_reload_r;
  logic [3:0]  window_width_r;

  logic [7:0]  win_low_r, win_low_nxt;
  logic [7:0]  win_high_r, win_high_nxt;
  logic [7:0]  squelch_r, squelch_nxt;
  logic [15:0] hang_cnt_r, hang_cnt_nxt;
  logic [15:0] tout_cnt_r, tout_cnt_nxt;
  logic        tout_armed_r, tout_armed_nxt;
  logic        key_r, key_nxt;
  logic [3:0]  tone_r, tone_nxt;
  logic [15:0] target_r, target_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] compare_r, compare_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        pop;
  logic [7:0]  avg;
  logic [7:0]  lvl_low, lvl_high, centre;
  logic        above_sq, below_margin;
  logic [4:0]  hit_pos;
  logic [3:0]  lvl_tone;
  logic [15:0] lvl_hang, lvl_hang_dec, lvl_tout, lvl_tout_dec;
  logic        lvl_armed, lvl_key;
  logic [8:0]  knob_sum;
  logic [15:0] period_step;

  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;
  assign avg     = q_cmd.data;

  // level step worked out from the current state for the head command
  always_comb begin
    lvl_low  = win_low_r;
    lvl_high = win_high_r;
    if (avg > win_high_r) begin
      lvl_high = avg;
      lvl_low  = avg - 8'(window_width_r);
    end else if (avg < win_low_r) begin
      lvl_low  = avg;
      lvl_high = avg + 8'(window_width_r);
    end
    centre = lvl_low + 8'(window_width_r >> 1);

    // first slot whose level lies above the centre
    hit_pos = 5'(TONE_COUNT);
    for (int j = TONE_COUNT - 1; j >= 1; j--) begin
      if (centre < ((j == 1) ? squelch_r : LEVEL_TABLE[j])) begin
        hit_pos = 5'(j);
      end
    end

    above_sq     = (centre >= squelch_r);
    below_margin = ({1'b0, centre} + 9'(window_width_r)) <= {1'b0, squelch_r};

    lvl_hang  = hang_cnt_r;
    lvl_tout  = tout_cnt_r;
    lvl_armed = tout_armed_r;
    lvl_tone  = 4'(hit_pos - 5'd1);
    if (above_sq) begin
      lvl_hang = hang_reload_r;
      if (!tout_armed_r) begin
        lvl_armed = 1'b1;
        lvl_tout  = timeout_reload_r;
      end
    end else if (below_margin) begin
      lvl_armed = 1'b0;
      lvl_tone  = '0;
    end else if (hang_cnt_r != '0) begin
      lvl_hang = hang_reload_r;
    end

    // hang and timeout countdown
    lvl_key      = key_r;
    lvl_hang_dec = lvl_hang - 16'd1;
    lvl_tout_dec = lvl_tout - 16'd1;
    if (lvl_hang != '0) begin
      if (lvl_hang_dec == '0) begin
        lvl_key = 1'b0;
      end else if (lvl_armed && lvl_tout != '0) begin
        lvl_key = (lvl_tout_dec != '0);
      end
    end
  end

  assign knob_sum = {1'b0, q_cmd.data} + 9'(window_width_r);

  always_comb begin
    if (period_r < target_r) begin
      period_step = period_r + 16'd1;
    end else begin
      period_step = period_r - 16'd1;
    end
  end

  always_comb begin
    win_low_nxt    = win_low_r;
    win_high_nxt   = win_high_r;
    squelch_nxt    = squelch_r;
    hang_cnt_nxt   = hang_cnt_r;
    tout_cnt_nxt   = tout_cnt_r;
    tout_armed_nxt = tout_armed_r;
    key_nxt        = key_r;
    tone_nxt       = tone_r;
    target_nxt     = target_r;
    period_nxt     = period_r;
    compare_nxt    = compare_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (pop) begin
      out_valid_nxt = 1'b1;
      unique case (q_cmd.kind)
        CMD_LEVEL: begin
          win_low_nxt    = lvl_low;
          win_high_nxt   = lvl_high;
          tone_nxt       = lvl_tone;
          target_nxt     = period_rom[lvl_tone];
          tout_armed_nxt = lvl_armed;
          key_nxt        = lvl_key;
          if (lvl_hang != '0) begin
            hang_cnt_nxt = lvl_hang_dec;
            tout_cnt_nxt = (lvl_hang_dec != '0 && lvl_armed && lvl_tout != '0) ?
                           lvl_tout_dec : lvl_tout;
          end else begin
            hang_cnt_nxt = lvl_hang;
            tout_cnt_nxt = lvl_tout;
          end
        end
        CMD_KNOB: begin
          squelch_nxt = knob_sum[8] ? 8'd255 : knob_sum[7:0];
        end
        CMD_TICK: begin
          if (period_r != target_r) begin
            period_nxt  = period_step;
            compare_nxt = 16'((17'(period_step) + 17'd1) >> 1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hang_reload_r    <= HANG_RELOAD_RST;
      timeout_reload_r <= TIMEOUT_RELOAD_RST;
      window_width_r   <= WINDOW_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HANG_RELOAD:    hang_reload_r    <= cfg_wdata;
        CFG_TIMEOUT_RELOAD: timeout_reload_r <= cfg_wdata;
        CFG_WINDOW_WIDTH:   window_width_r   <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r    <= '0;
      win_high_r   <= 8'(WINDOW_WIDTH_RST);
      squelch_r    <= 8'd255;
      hang_cnt_r   <= '0;
      tout_cnt_r   <= '0;
      tout_armed_r <= 1'b0;
      key_r        <= 1'b0;
      tone_r       <= '0;
      target_r     <= period_rom[0];
      period_r     <= 16'd1;
      compare_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      win_low_r    <= win_low_nxt;
      win_high_r   <= win_high_nxt;
      squelch_r    <= squelch_nxt;
      hang_cnt_r   <= hang_cnt_nxt;
      tout_cnt_r   <= tout_cnt_nxt;
      tout_armed_r <= tout_armed_nxt;
      key_r        <= key_nxt;
      tone_r       <= tone_nxt;
      target_r     <= target_nxt;
      period_r     <= period_nxt;
      compare_r    <= compare_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_transmit_key  = key_r;
  assign out_tone_index    = tone_r;
  assign out_period_target = target_r;
  assign out_period_now    = period_r;
  assign out_compare_now   = compare_r;

endmodule

`default_nettype wire

// File: rtl/core/slt_port_monitor.sv
// port-level assertions for the signal level tone squelch block
// bound to signal_level_tone_squelch_ptt_top; uses slt_pkg
`default_nettype none

module slt_port_monitor
  import slt_pkg::*;
#(
  parameter int TONE_COUNT = TONE_COUNT_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_transmit_key,
  input wire logic [3:0]  out_tone_index,
  input wire logic [15:0] out_period_target,
  input wire logic [15:0] out_period_now,
  input wire logic [15:0] out_compare_now
);

  // a stalled result keeps its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period_now)
      && $stable(out_compare_now) && $stable(out_transmit_key))
    else $error("result transaction changed while stalled");

  // compare value follows the period once the period has moved
  a_compare_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_now != 16'd0 |->
      out_compare_now == 16'((17'(out_period_now) + 17'd1) >> 1))
    else $error("compare value is not half the period");

  // tone selection stays inside the table
  a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_tone_index) < TONE_COUNT)
    else $error("tone index beyond tone count");

  // the period moves at most one step per result transaction
  a_period_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid |->
      out_period_now == $past(out_period_now)
      || out_period_now == $past(out_period_now) + 16'd1
      || out_period_now == $past(out_period_now) - 16'd1)
    else $error("period jumped by more than one step");

  // input side is never blocked while the back end is empty and draining
  a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid ##1 !in_valid && !out_valid |-> in_ready)
    else $error("input not ready while the block is idle");

endmodule

bind signal_level_tone_squelch_ptt_top slt_port_monitor #(
  .TONE_COUNT (TONE_COUNT)
) u_port_monitor (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_transmit_key  (out_transmit_key),
  .out_tone_index    (out_tone_index),
  .out_period_target (out_period_target),
  .out_period_now    (out_period_now),
  .out_compare_now   (out_compare_now)
);

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for signal_level_tone_squelch_ptt_top
// depends on slt_pkg and the block's rtl; a scoreboard class predicts every result
`timescale 1ns / 100ps

module testbench;
  import slt_pkg::*;

  // operation 3 and register index 3 are not in the package; the block must ignore them
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 125;
  localparam int HOLD_CYCLES  = 48;   // long receiver hold-off to fill the queue
  localparam int DRAIN_PAD    = 6;    // out_valid trails acceptance behind the queue, leave slack
  localparam int STALL_LIMIT  = 2000; // cycles with no transaction before giving up

  // register settings per phase, extremes included
  localparam int HANG_PLAN  [PHASES] = '{1, 65535, 0, 3, 20, 8};
  localparam int TMO_PLAN   [PHASES] = '{1, 65535, 0, 12, 200, 40};
  localparam int WIDTH_PLAN [PHASES] = '{0, 15, 4, 7, 2, 1};

  typedef struct packed {
    logic        key;
    logic [3:0]  tone;
    logic [15:0] target;
    logic [15:0] period;
    logic [15:0] compare;
  } squelch_result_t;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // predicts the block's state after each accepted input and checks results in order
  class tone_key_scoreboard;
    logic [15:0] hang_rl, tmo_rl;
    logic [3:0]  width;
    logic [9:0]  level_sum;
    int          level_cnt;
    logic [7:0]  win_low, win_high, squelch;
    logic [15:0] hang, tmo;
    bit          armed, key;
    logic [3:0]  tone;
    logic [15:0] tgt, now, cmp;
    logic [15:0] period_of [TABLE_SLOTS];
    squelch_result_t pending_results [$];
    int errors, checked, key_rises, expiries, locks;

    function new();
      for (int j = 0; j < TABLE_SLOTS; j++)
        period_of[j] = 16'((((2 * CLOCK_HZ_DEF) / TONE_FREQ[j]) + 1) / 2 - 1);
      hang_rl   = HANG_RELOAD_RST;
      tmo_rl    = TIMEOUT_RELOAD_RST;
      width     = WINDOW_WIDTH_RST;
      level_sum = '0;
      level_cnt = 0;
      win_low   = 8'd0;
      win_high  = {4'd0, WINDOW_WIDTH_RST};
      squelch   = 8'd255;
      hang      = '0;
      tmo       = '0;
      armed     = 0;
      key       = 0;
      tone      = '0;
      tgt       = period_of[0];
      now       = 16'd1;
      cmp       = '0;
      errors    = 0;
      checked   = 0;
      key_rises = 0;
      expiries  = 0;
      locks     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_HANG_RELOAD:    hang_rl = val;
        CFG_TIMEOUT_RELOAD: tmo_rl  = val;
        CFG_WINDOW_WIDTH:   width   = val[3:0];
        default: ;
      endcase
    endfunction

    // one averaged level: window tracking, tone match, squelch, hang and timeout
    function void update_level(logic [7:0] avg);
      int         i, margin;
      bit         hit, was_keyed;
      logic [7:0] centre, lvl;
      was_keyed = key;
      if (avg > win_high) begin
        win_high = avg;
        win_low  = win_high - width;
      end else if (avg < win_low) begin
        win_low  = avg;
        win_high = win_low + width;
      end
      centre = win_low + (width >> 1);
      i = 1;
      hit = 0;
      while (!hit && i < TONE_COUNT_DEF && i < TABLE_SLOTS) begin
        lvl = (i == 1) ? squelch : LEVEL_TABLE[i];
        if (centre < lvl) hit = 1;
        else i++;
      end
      margin = int'(squelch) - int'(width);
      if (centre >= squelch) begin
        hang = hang_rl;
        if (!armed) begin
          armed = 1;
          tmo   = tmo_rl;
        end
      end else if (int'(centre) <= margin) begin
        armed = 0;
        i = 1;
      end else if (hang > 0) begin
        hang = hang_rl;
      end
      tone = 4'(i - 1);
      tgt  = period_of[tone];
      if (hang > 0) begin
        hang--;
        if (hang == 0) begin
          key = 0;
        end else if (armed && tmo > 0) begin
          tmo--;
          key = (tmo != 0);
          if (tmo == 0) expiries++;
        end
      end
      if (key && !was_keyed) key_rises++;
    endfunction

    function void advance_state(logic [1:0] op, logic [7:0] s);
      squelch_result_t r;
      case (op)
        OP_SIGNAL: begin
          level_sum = level_sum + s;
          level_cnt++;
          if (level_cnt >= AVG_COUNT) begin
            level_cnt = 0;
            update_level(8'(level_sum / AVG_COUNT));
            level_sum = '0;
          end
        end
        OP_KNOB: begin
          if (int'(s) > 255 - int'(width)) squelch = 8'd255;
          else squelch = s + width;
        end
        OP_TICK: begin
          if (now != tgt) begin
            if (now < tgt) now++;
            else now--;
            cmp = 16'((17'(now) + 17'd1) >> 1);
            if (now == tgt) locks++;
          end
        end
        default: ;
      endcase
      r.key     = key;
      r.tone    = tone;
      r.target  = tgt;
      r.period  = now;
      r.compare = cmp;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    task compare_result(logic k, logic [3:0] t, logic [15:0] pt, logic [15:0] pn,
                        logic [15:0] pc);
      squelch_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: tone %0d period %0d", t, pn));
        return;
      end
      want = pending_results.pop_front();
      if (k !== want.key)
        report($sformatf("result %0d transmit_key %b, want %b", checked, k, want.key));
      if (t !== want.tone)
        report($sformatf("result %0d tone_index %0d, want %0d", checked, t, want.tone));
      if (pt !== want.target)
        report($sformatf("result %0d period_target %0d, want %0d", checked, pt, want.target));
      if (pn !== want.period)
        report($sformatf("result %0d period_now %0d, want %0d", checked, pn, want.period));
      if (pc !== want.compare)
        report($sformatf("result %0d compare_now %0d, want %0d", checked, pc, want.compare));
      checked++;
    endtask
  endclass

  // clock, reset and every block input start at known values
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = '0;
  logic [15:0] cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_sample    = '0;
  logic        out_ready    = 1'b0;

  logic        in_ready, out_valid, out_transmit_key;
  logic [3:0]  out_tone_index;
  logic [15:0] out_period_target, out_period_now, out_compare_now;

  tone_key_scoreboard sb;

  // sender bookkeeping
  bit steady     = 0;  // no gaps while set
  int burst_left = 0;
  int sent       = 0;
  int drift_lvl  = 60; // slowly wandering signal level for well-formed groups

  // receiver bookkeeping
  int       hold_requests = 0;
  int       holds_done    = 0;
  int       hold_left     = 0;
  rx_mode_t rx_mode       = RX_STREAM;
  int       rx_span       = 0;
  int       rx_tick       = 0;

  signal_level_tone_squelch_ptt_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_transmit_key  (out_transmit_key),
    .out_tone_index    (out_tone_index),
    .out_period_target (out_period_target),
    .out_period_now    (out_period_now),
    .out_compare_now   (out_compare_now)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one input transaction: hold valid and payload until accepted, then predict
  task automatic push_item(logic [1:0] op, logic [7:0] s);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_sample    <= s;
    do @(posedge clk); while (!in_ready);
    sb.advance_state(op, s);
    sent++;
  endtask

  // bursty sender: random gap between bursts, some long bursts with no idling
  task automatic offer(logic [1:0] op, logic [7:0] s);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    push_item(op, s);
  endtask

  // one random action; mostly well-formed groups of four signal samples
  task automatic random_action();
    int         pick, v, n;
    logic [7:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // pick a new level or let the old one wander
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: drift_lvl = $urandom_range(0, 255);
          1: drift_lvl = int'(sb.squelch) + $urandom_range(0, 12) - 6;
          2: drift_lvl = int'(LEVEL_TABLE[$urandom_range(2, 10)]) + $urandom_range(0, 6) - 3;
          default: drift_lvl = ($urandom_range(0, 1) == 0) ? 0 : 255;
        endcase
      end else begin
        drift_lvl = drift_lvl + $urandom_range(0, 6) - 3;
      end
      drift_lvl = (drift_lvl < 0) ? 0 : (drift_lvl > 255) ? 255 : drift_lvl;
      repeat (4) begin
        v = drift_lvl + $urandom_range(0, 4) - 2;
        s = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        offer(OP_SIGNAL, s);
      end
    end else if (pick < 67) begin
      // squelch knob: anywhere, at the saturation edge, or in the working range
      case ($urandom_range(0, 3))
        0: s = 8'($urandom);
        1: begin
          case ($urandom_range(0, 3))
            0: s = 8'd0;
            1: s = 8'd255;
            2: s = 8'(255 - sb.width);
            default: s = 8'(256 - sb.width);
          endcase
        end
        default: s = 8'($urandom_range(20, 110));
      endcase
      offer(OP_KNOB, s);
    end else if (pick < 87) begin
      n = $urandom_range(1, 8);
      repeat (n) offer(OP_TICK, 8'($urandom));
    end else if (pick < 92) begin
      offer(OP_UNUSED, 8'($urandom));
    end else begin
      // lone sample that shifts the grouping
      offer(OP_SIGNAL, 8'($urandom));
    end
  endtask

  // wait for every expected result, then for the DRAIN_PAD slack
  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // receiver: check each result transaction, then choose the next ready
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.compare_result(out_transmit_key, out_tone_index, out_period_target,
                        out_period_now, out_compare_now);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < hold_requests) begin
      // long hold-off: the block has to fill up and drop in_ready
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(8, 80);
      end
      rx_span--;
      rx_tick++;
      case (rx_mode)
        RX_STREAM:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE:   out_ready <= ($urandom_range(0, 7) != 0);
        default:     out_ready <= ((rx_tick % 5) < 2);
      endcase
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("signal_level_tone_squelch_ptt_top verification failed");
    $finish;
  end

  // main sequence: reset, directed items, then phases of register settings
  initial begin : stimulus
    int ph, start;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset settings
    offer(OP_UNUSED, 8'hFF);           // unused operation changes nothing
    offer(OP_TICK, 8'h00);             // first slide step
    offer(OP_KNOB, 8'd255);            // knob saturation
    offer(OP_KNOB, 8'd254);
    offer(OP_KNOB, 8'd253);            // just at the saturation edge
    offer(OP_KNOB, 8'd0);              // lowest squelch
    repeat (4) offer(OP_SIGNAL, 8'd0); // floor level group
    offer(OP_KNOB, 8'd40);
    repeat (4) offer(OP_SIGNAL, 8'd255); // full scale, keys the line, top tone
    offer(OP_TICK, 8'hFF);
    offer(OP_SIGNAL, 8'h80);           // mixed bit patterns in one group
    offer(OP_SIGNAL, 8'h7F);
    offer(OP_SIGNAL, 8'h01);
    offer(OP_SIGNAL, 8'hFE);
    repeat (4) offer(OP_SIGNAL, 8'd0); // clearly below squelch, disarms
    offer(OP_UNUSED, 8'h55);

    for (ph = 0; ph < PHASES; ph++) begin
      // registers only change with the block idle
      in_valid <= 1'b0;
      drain();
      cfg_we    <= 1'b1;
      cfg_index <= CFG_HANG_RELOAD;
      cfg_wdata <= 16'(HANG_PLAN[ph]);
      sb.set_reg(CFG_HANG_RELOAD, 16'(HANG_PLAN[ph]));
      @(posedge clk);
      cfg_index <= CFG_TIMEOUT_RELOAD;
      cfg_wdata <= 16'(TMO_PLAN[ph]);
      sb.set_reg(CFG_TIMEOUT_RELOAD, 16'(TMO_PLAN[ph]));
      @(posedge clk);
      cfg_index <= CFG_WINDOW_WIDTH;
      cfg_wdata <= 16'(WIDTH_PLAN[ph]);
      sb.set_reg(CFG_WINDOW_WIDTH, 16'(WIDTH_PLAN[ph]));
      @(posedge clk);
      // write outside the register list, must be ignored
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
      cfg_we <= 1'b0;

      if (ph == 1) begin
        // back pressure: receiver holds off while the sender keeps offering
        steady = 1;
        hold_requests++;
        repeat (8) random_action();
        steady = 0;
      end

      start = sent;
      while (sent - start < PHASE_ITEMS) random_action();

      if (ph == 4) begin
        // a long run of back to back period ticks
        repeat (24) offer(OP_TICK, 8'($urandom));
      end

      // squelch left below the next phase's wider margin
      if (WIDTH_PLAN[ph] == 0) offer(OP_KNOB, 8'd0);
    end

    in_valid <= 1'b0;
    drain();
    $display("covered %0d input transactions over %0d register settings, %0d results checked",
             sent, PHASES + 1, sb.checked);
    $display("key raised %0d times, %0d timeouts expired, period locked %0d times",
             sb.key_rises, sb.expiries, sb.locks);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("signal_level_tone_squelch_ptt_top verification clean");
    end else begin
      $display("signal_level_tone_squelch_ptt_top verification failed");
    end
    $finish;
  end

endmodule
